@@ rtl/lcdw_pkg.sv @@
// shared types, constants and the init event table for the character display sequencer
// no dependencies
package lcdw_pkg;

  // request codes
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_MOVE  = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  // register indexes (paddr[2] selects)
  localparam logic REG_WRAP_COLUMN = 1'b0;
  localparam logic REG_WRAP_ENABLE = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [6:0] WRAP_COLUMN_RST = 7'd20;
  localparam logic       WRAP_ENABLE_RST = 1'b1;
  localparam logic [6:0] COUNT_MAX       = 7'd127;

  // character substitution
  localparam logic [7:0] CHAR_SUB_A = 8'd241;
  localparam logic [7:0] CHAR_SUB_B = 8'd209;
  localparam logic [7:0] CHAR_REPL  = 8'd238;

  // display commands
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] LINE2_ADDR     = 8'h40;
  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'b00001100;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;
  localparam logic [7:0] CMD_WRAP       = CMD_SET_DDRAM | LINE2_ADDR;

  // waits in microseconds
  localparam logic [14:0] WAIT_NONE     = 15'd0;
  localparam logic [14:0] WAIT_BYTE     = 15'd2000;
  localparam logic [14:0] WAIT_CLEAR    = 15'd4000;
  localparam logic [14:0] WAIT_POWER    = 15'd15000;
  localparam logic [14:0] WAIT_WAKE1    = 15'd5000;
  localparam logic [14:0] WAIT_WAKE2    = 15'd100;
  localparam logic [14:0] WAIT_WAKE3    = 15'd40;
  localparam logic [14:0] WAIT_INIT_END = 15'd17000;

  // event index within a job
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] INIT_LAST = 4'd9;
  localparam logic [IDX_W-1:0] BYTE_LAST = 4'd3;

  // queue sizing
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic        strobe_res;
    logic        rs;
    logic [3:0]  nibble;
    logic [14:0] wait_us;
    logic        last;
  } evt_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        is_init;
    logic        rs;
    logic [7:0]  data;
    logic [14:0] wait_last;
    logic        wrap;
  } job_t;

  typedef struct packed {
    logic [6:0] wrap_column;
    logic       wrap_enable;
  } cfg_t;

  function automatic evt_t mk_evt(logic strobe, logic [3:0] nib, logic [14:0] w,
                                  logic lst);
    evt_t e;
    e.strobe_res = strobe;
    e.rs         = 1'b0;
    e.nibble     = nib;
    e.wait_us    = w;
    e.last       = lst;
    return e;
  endfunction

  // power-up reset sequence, one event per index
  function automatic evt_t init_event(logic [IDX_W-1:0] idx);
    evt_t e;
    case (idx)
      4'd0:    e = mk_evt(1'b0, 4'h0, WAIT_POWER, 1'b0);
      4'd1:    e = mk_evt(1'b1, NIB_WAKE, WAIT_WAKE1, 1'b0);
      4'd2:    e = mk_evt(1'b1, NIB_WAKE, WAIT_WAKE2, 1'b0);
      4'd3:    e = mk_evt(1'b1, NIB_4BIT, WAIT_WAKE3, 1'b0);
      4'd4:    e = mk_evt(1'b1, CMD_FUNC_SET[7:4], WAIT_NONE, 1'b0);
      4'd5:    e = mk_evt(1'b1, CMD_FUNC_SET[3:0], WAIT_BYTE, 1'b0);
      4'd6:    e = mk_evt(1'b1, CMD_DISP_ON[7:4], WAIT_NONE, 1'b0);
      4'd7:    e = mk_evt(1'b1, CMD_DISP_ON[3:0], WAIT_BYTE, 1'b0);
      4'd8:    e = mk_evt(1'b1, CMD_CLEAR[7:4], WAIT_NONE, 1'b0);
      4'd9:    e = mk_evt(1'b1, CMD_CLEAR[3:0], WAIT_INIT_END, 1'b1);
      default: e = mk_evt(1'b0, 4'h0, WAIT_NONE, 1'b1);
    endcase
    return e;
  endfunction

endpackage

@@ rtl/lcdw_front.sv @@
// front end: accepts requests, tracks the column count and builds jobs
// depends on lcdw_pkg
module lcdw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  lcdw_pkg::req_t   req_data,
  input  lcdw_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output lcdw_pkg::job_t   job
);

  logic [6:0] column_count;
  logic [6:0] column_count_next;
  logic [6:0] count_inc;
  logic [7:0] ch;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // saturating character count
  assign count_inc = (column_count < lcdw_pkg::COUNT_MAX) ? column_count + 7'd1 : column_count;

  // character code substitution
  always_comb begin
    ch = req_data.value;
    if (req_data.value == lcdw_pkg::CHAR_SUB_A || req_data.value == lcdw_pkg::CHAR_SUB_B) begin
      ch = lcdw_pkg::CHAR_REPL;
    end
  end

  // classify request into a job
  always_comb begin
    job               = '0;
    column_count_next = 7'd0;
    case (req_data.req_type)
      lcdw_pkg::REQ_INIT: begin
        job.is_init = 1'b1;
      end
      lcdw_pkg::REQ_CLEAR: begin
        job.data      = lcdw_pkg::CMD_CLEAR;
        job.wait_last = lcdw_pkg::WAIT_CLEAR;
      end
      lcdw_pkg::REQ_MOVE: begin
        job.data      = lcdw_pkg::CMD_SET_DDRAM + req_data.value;
        job.wait_last = lcdw_pkg::WAIT_BYTE;
      end
      lcdw_pkg::REQ_WRITE: begin
        job.rs            = 1'b1;
        job.data          = ch;
        job.wait_last     = lcdw_pkg::WAIT_BYTE;
        job.wrap          = cfg.wrap_enable && (count_inc == cfg.wrap_column);
        column_count_next = count_inc;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 7'd0;
    end else if (push) begin
      column_count <= column_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    push && req_data.req_type != lcdw_pkg::REQ_WRITE |=> column_count == 7'd0)
    else $error("column count not cleared by init, clear or move");
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    push && req_data.req_type == lcdw_pkg::REQ_WRITE && column_count != lcdw_pkg::COUNT_MAX
    |=> column_count == $past(column_count) + 7'd1)
    else $error("column count did not advance on a character write");
  a_wrap_write_only: assert property (@(posedge clk) disable iff (rst)
    push && job.wrap |-> job.rs && !job.is_init)
    else $error("wrap requested on a non-character job");
`endif

endmodule

@@ rtl/lcdw_queue.sv @@
// two-entry job queue between the front end and the event sequencer
// depends on lcdw_pkg
module lcdw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lcdw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lcdw_pkg::job_t head
);

  lcdw_pkg::job_t                  entries [lcdw_pkg::QDEPTH];
  logic [lcdw_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lcdw_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lcdw_pkg::QCNT_W-1:0]     count;

  assign full    = (count == lcdw_pkg::QCNT_W'(lcdw_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= lcdw_pkg::QCNT_W'(lcdw_pkg::QDEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

@@ rtl/lcdw_back.sv @@
// back end: turns each job into bus events, one per cycle unless stalled, in an output register
// depends on lcdw_pkg
module lcdw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lcdw_pkg::job_t head,
  output logic           pop,
  output logic           evt_valid,
  input  logic           evt_stall,
  output lcdw_pkg::evt_t evt_data
);

  logic [lcdw_pkg::IDX_W-1:0] idx;
  logic                       advance;
  lcdw_pkg::evt_t             ev;

  assign advance = q_valid && (!evt_valid || !evt_stall);
  assign pop     = advance && ev.last;

  // event for the current index of the head job
  always_comb begin
    ev = lcdw_pkg::init_event(idx);
    if (!head.is_init) begin
      ev.strobe_res = 1'b1;
      case (idx[1:0])
        2'd0: begin
          ev.rs      = head.rs;
          ev.nibble  = head.data[7:4];
          ev.wait_us = lcdw_pkg::WAIT_NONE;
          ev.last    = 1'b0;
        end
        2'd1: begin
          ev.rs      = head.rs;
          ev.nibble  = head.data[3:0];
          ev.wait_us = head.wait_last;
          ev.last    = !head.wrap;
        end
        2'd2: begin
          ev.rs      = 1'b0;
          ev.nibble  = lcdw_pkg::CMD_WRAP[7:4];
          ev.wait_us = lcdw_pkg::WAIT_NONE;
          ev.last    = 1'b0;
        end
        default: begin
          ev.rs      = 1'b0;
          ev.nibble  = lcdw_pkg::CMD_WRAP[3:0];
          ev.wait_us = lcdw_pkg::WAIT_BYTE;
          ev.last    = 1'b1;
        end
      endcase
    end
  end

  // event index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      evt_valid <= 1'b0;
    end else begin
      if (advance) begin
        idx       <= ev.last ? '0 : idx + 1'b1;
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      evt_data <= ev;
    end
  end

`ifndef ASSERT_OFF
  a_idx_init: assert property (@(posedge clk) disable iff (rst) idx <= lcdw_pkg::INIT_LAST)
    else $error("event index past the init sequence");
  a_idx_byte: assert property (@(posedge clk) disable iff (rst)
    q_valid && !head.is_init |-> idx <= lcdw_pkg::BYTE_LAST)
    else $error("event index past a byte job");
  a_idx_restart: assert property (@(posedge clk) disable iff (rst) pop |=> idx == '0)
    else $error("event index not rewound after a job");
`endif

endmodule

@@ rtl/char_lcd_4bit_write_sequencer_core.sv @@
// top level of the character display write sequencer: register port, front, queue, back
// depends on lcdw_pkg, lcdw_front, lcdw_queue, lcdw_back
//
// Each accepted request becomes a run of 4-bit bus events on the evt channel, one event per
// clock while evt_stall is low: 10 for init, 2 for clear, move and character write, and 4 for
// a character write that triggers the automatic jump to line two. The back end sets the rate;
// the front end takes a request every cycle while the two-entry job queue has room, so
// requests overlap the events of earlier ones. A request's first event passes through its
// queue entry and then the output register. Registers: wrap_column at byte address 0 and
// wrap_enable at 4; the user must write them via APB only while idle, which is not enforced.
module char_lcd_4bit_write_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcdw_pkg::PADDR_W-1:0]   paddr,
  input  logic [lcdw_pkg::PDATA_W-1:0]   pwdata,
  output logic [lcdw_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lcdw_pkg::req_t                 req_data,
  output logic                           evt_valid,
  input  logic                           evt_stall,
  output lcdw_pkg::evt_t                 evt_data
);

  lcdw_pkg::cfg_t cfg;
  lcdw_pkg::job_t job;
  lcdw_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_column <= lcdw_pkg::WRAP_COLUMN_RST;
      cfg.wrap_enable <= lcdw_pkg::WRAP_ENABLE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        lcdw_pkg::REG_WRAP_COLUMN: cfg.wrap_column <= pwdata[6:0];
        lcdw_pkg::REG_WRAP_ENABLE: cfg.wrap_enable <= pwdata[0];
        default:                   cfg <= cfg;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      lcdw_pkg::REG_WRAP_COLUMN: prdata = {25'd0, cfg.wrap_column};
      lcdw_pkg::REG_WRAP_ENABLE: prdata = {31'd0, cfg.wrap_enable};
      default:                   prdata = '0;
    endcase
  end

  lcdw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  lcdw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  lcdw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data)
  );

endmodule

@@ sim/char_lcd_4bit_write_sequencer_checker.sv @@
// checker for the character display write sequencer: predicts bus events from each request
// transfer and compares them with the event transfers; depends on lcdw_pkg
module char_lcd_4bit_write_sequencer_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdw_pkg::PADDR_W-1:0] paddr,
  input  logic [lcdw_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  input  logic                         req_valid,
  input  logic                         req_stall,
  input  lcdw_pkg::req_t               req_data,
  input  logic                         evt_valid,
  input  logic                         evt_stall,
  input  lcdw_pkg::evt_t               evt_data,
  output int                           fail_count,
  output int                           pending,
  output int                           events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // waits in microseconds
  localparam logic [14:0] US_NONE     = 15'd0;
  localparam logic [14:0] US_BYTE     = 15'd2000;
  localparam logic [14:0] US_CLEAR    = 15'd4000;
  localparam logic [14:0] US_POWER    = 15'd15000;
  localparam logic [14:0] US_WAKE1    = 15'd5000;
  localparam logic [14:0] US_WAKE2    = 15'd100;
  localparam logic [14:0] US_WAKE3    = 15'd40;
  localparam logic [14:0] US_INIT_END = 15'd17000;

  // command bytes and character codes
  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] BYTE_GOTO  = 8'h80;
  localparam logic [7:0] BYTE_LINE2 = 8'hC0;
  localparam logic [7:0] BYTE_FUNC  = 8'h28;
  localparam logic [7:0] BYTE_DISP  = 8'h0C;
  localparam logic [3:0] NIB_WAKE   = 4'h3;
  localparam logic [3:0] NIB_FOUR   = 4'h2;
  localparam logic [7:0] CH_ODD_A   = 8'd241;
  localparam logic [7:0] CH_ODD_B   = 8'd209;
  localparam logic [7:0] CH_STAND   = 8'd238;
  localparam logic [6:0] CHARS_MAX  = 7'd127;

  localparam int PRINT_CAP = 40;

  logic [6:0]     cfg_wrap_col  = 7'd20;
  logic           cfg_wrap_en   = 1'b1;
  logic [6:0]     chars_on_line = 7'd0;
  lcdw_pkg::evt_t events_due[$];
  int             n_fail = 0;
  int             n_seen = 0;

  task automatic report_mismatch(string msg);
    if (n_fail < PRINT_CAP) $display("[%0t] checker: %s", $realtime, msg);
    n_fail++;
  endtask

  task automatic push_event(logic strobe, logic rsel, logic [3:0] nib, logic [14:0] w,
                            logic lst);
    lcdw_pkg::evt_t e;
    e.strobe_res = strobe;
    e.rs         = rsel;
    e.nibble     = nib;
    e.wait_us    = w;
    e.last       = lst;
    events_due.push_back(e);
  endtask

  // high nibble goes first without a wait
  task automatic push_byte(logic rsel, logic [7:0] b, logic [14:0] w, logic lst);
    push_event(1'b1, rsel, b[7:4], US_NONE, 1'b0);
    push_event(1'b1, rsel, b[3:0], w, lst);
  endtask

  // expand one request into the bus events it must produce
  task automatic expand_request(lcdw_pkg::req_t r);
    logic [7:0] ch;
    logic       wrap;
    logic [7:0] goto_byte;
    case (r.req_type)
      lcdw_pkg::REQ_INIT: begin
        push_event(1'b0, 1'b0, 4'h0, US_POWER, 1'b0);
        push_event(1'b1, 1'b0, NIB_WAKE, US_WAKE1, 1'b0);
        push_event(1'b1, 1'b0, NIB_WAKE, US_WAKE2, 1'b0);
        push_event(1'b1, 1'b0, NIB_FOUR, US_WAKE3, 1'b0);
        push_byte(1'b0, BYTE_FUNC, US_BYTE, 1'b0);
        push_byte(1'b0, BYTE_DISP, US_BYTE, 1'b0);
        push_byte(1'b0, BYTE_CLEAR, US_INIT_END, 1'b1);
        chars_on_line = 7'd0;
      end
      lcdw_pkg::REQ_CLEAR: begin
        push_byte(1'b0, BYTE_CLEAR, US_CLEAR, 1'b1);
        chars_on_line = 7'd0;
      end
      lcdw_pkg::REQ_MOVE: begin
        // positions of 128 and up wrap into other command codes
        goto_byte = BYTE_GOTO + r.value;
        push_byte(1'b0, goto_byte, US_BYTE, 1'b1);
        chars_on_line = 7'd0;
      end
      default: begin
        ch = (r.value == CH_ODD_A || r.value == CH_ODD_B) ? CH_STAND : r.value;
        if (chars_on_line < CHARS_MAX) chars_on_line = chars_on_line + 7'd1;
        // a saturated count keeps matching a wrap column of 127
        wrap = cfg_wrap_en && (chars_on_line == cfg_wrap_col);
        push_byte(1'b1, ch, US_BYTE, !wrap);
        if (wrap) push_byte(1'b0, BYTE_LINE2, US_BYTE, 1'b1);
      end
    endcase
  endtask

  task automatic compare_event(lcdw_pkg::evt_t want, lcdw_pkg::evt_t got);
    if (got.strobe_res !== want.strobe_res)
      report_mismatch($sformatf("event %0d strobe %b, want %b", n_seen, got.strobe_res,
                                want.strobe_res));
    if (got.rs !== want.rs)
      report_mismatch($sformatf("event %0d rs %b, want %b", n_seen, got.rs, want.rs));
    if (got.nibble !== want.nibble)
      report_mismatch($sformatf("event %0d nibble %h, want %h", n_seen, got.nibble,
                                want.nibble));
    if (got.wait_us !== want.wait_us)
      report_mismatch($sformatf("event %0d wait %0d, want %0d", n_seen, got.wait_us,
                                want.wait_us));
    if (got.last !== want.last)
      report_mismatch($sformatf("event %0d last %b, want %b", n_seen, got.last, want.last));
  endtask

  // watch register writes, event transfers and request transfers
  always @(posedge clk) begin
    if (rst) begin
      cfg_wrap_col  = 7'd20;
      cfg_wrap_en   = 1'b1;
      chars_on_line = 7'd0;
      events_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == lcdw_pkg::REG_WRAP_COLUMN) cfg_wrap_col = pwdata[6:0];
        else cfg_wrap_en = pwdata[0];
      end
      // results come from earlier requests, so check before expanding a new one
      if (evt_valid && !evt_stall) begin
        n_seen++;
        if (events_due.size() == 0)
          report_mismatch($sformatf("event %0d arrived with nothing due", n_seen));
        else
          compare_event(events_due.pop_front(), evt_data);
      end
      if (req_valid && !req_stall) expand_request(req_data);
    end
    fail_count  <= n_fail;
    pending     <= events_due.size();
    events_seen <= n_seen;
  end

endmodule

@@ sim/tb_char_lcd_4bit_write_sequencer_core.sv @@
// testbench top for the character display write sequencer: clock, reset, register writes,
// request stimulus and event stalls; depends on lcdw_pkg, the core and the checker module
module tb_char_lcd_4bit_write_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 16;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [lcdw_pkg::PADDR_W-1:0] paddr     = '0;
  logic [lcdw_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [lcdw_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  logic                         req_valid = 1'b0;
  logic                         req_stall;
  lcdw_pkg::req_t               req_data  = '0;
  logic                         evt_valid;
  logic                         evt_stall = 1'b0;
  lcdw_pkg::evt_t               evt_data;

  int fail_count;
  int pending;
  int events_seen;
  int items_sent   = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int quiet_cycles = 0;
  bit idle_on      = 1'b0;
  bit calm_end     = 1'b0;

  char_lcd_4bit_write_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data)
  );

  char_lcd_4bit_write_sequencer_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .evt_data    (evt_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .events_seen (events_seen)
  );

  always #1 clk = ~clk;

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (evt_valid && !evt_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // event side: random stall bursts, plus a long hold when asked
  initial begin : event_receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        evt_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        evt_stall <= 1'b0;
      end else if (idle_on && !calm_end && $urandom_range(0, 4) == 0) begin
        evt_stall <= 1'b1;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
        evt_stall <= 1'b0;
      end
    end
  end

  // setup cycle, then access cycle; the write lands at the end of the access
  task automatic apb_write(logic [lcdw_pkg::PADDR_W-1:0] addr,
                           logic [lcdw_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one request transfer, with an optional idle burst ahead of it
  task automatic send_req(logic [1:0] kind, logic [7:0] val);
    lcdw_pkg::req_t r;
    int             n;
    r.req_type = kind;
    r.value    = val;
    if (idle_on && !calm_end && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  // character codes, leaning on the substituted ones now and then
  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 11);
    if (k == 0) return lcdw_pkg::CHAR_SUB_A;
    if (k == 1) return lcdw_pkg::CHAR_SUB_B;
    if (k == 2) return lcdw_pkg::CHAR_REPL;
    return 8'($urandom_range(0, 255));
  endfunction

  // a line: init, clear or move, then a run of characters
  task automatic send_line(int len);
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) send_req(lcdw_pkg::REQ_INIT, 8'($urandom_range(0, 255)));
    else if (k < 3) send_req(lcdw_pkg::REQ_CLEAR, 8'($urandom_range(0, 255)));
    else send_req(lcdw_pkg::REQ_MOVE, 8'($urandom_range(0, 255)));
    repeat (len) send_req(lcdw_pkg::REQ_WRITE, pick_char());
  endtask

  // wait until every due event has come out, plus the pipeline latency
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_wrap(logic [6:0] col, logic en);
    settle();
    apb_write({lcdw_pkg::REG_WRAP_COLUMN, 2'b00}, {25'd0, col});
    apb_write({lcdw_pkg::REG_WRAP_ENABLE, 2'b00}, {31'd0, en});
  endtask

  // mostly well-formed lines, some lone random requests, optional long hold midway
  task automatic run_phase(logic [6:0] col, logic en, int n_items, bit with_hold);
    int goal;
    int len;
    bit hold_left;
    set_wrap(col, en);
    goal      = items_sent + n_items;
    hold_left = with_hold;
    while (items_sent < goal) begin
      idle_on = !calm_end && ($urandom_range(0, 3) != 0);
      if (hold_left && items_sent >= goal - n_items / 2) begin
        // receiver holds off while requests keep coming
        hold_left = 1'b0;
        idle_on   = 1'b0;
        hold_asked++;
        repeat (24) send_req(lcdw_pkg::REQ_WRITE, pick_char());
      end else if ($urandom_range(0, 4) != 0) begin
        len = (col == 7'd0) ? $urandom_range(1, 8) : $urandom_range(1, int'(col) + 2);
        send_line(len);
      end else begin
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every request, extreme values, substituted characters
    idle_on = 1'b0;
    send_req(lcdw_pkg::REQ_INIT, 8'h00);
    send_req(lcdw_pkg::REQ_CLEAR, 8'hFF);
    send_req(lcdw_pkg::REQ_MOVE, 8'd0);
    send_req(lcdw_pkg::REQ_MOVE, 8'd127);
    send_req(lcdw_pkg::REQ_MOVE, 8'd128);
    send_req(lcdw_pkg::REQ_MOVE, 8'd255);
    send_req(lcdw_pkg::REQ_WRITE, 8'd0);
    send_req(lcdw_pkg::REQ_WRITE, 8'd255);
    send_req(lcdw_pkg::REQ_WRITE, lcdw_pkg::CHAR_SUB_A);
    send_req(lcdw_pkg::REQ_WRITE, lcdw_pkg::CHAR_SUB_B);
    send_req(lcdw_pkg::REQ_WRITE, lcdw_pkg::CHAR_REPL);
    send_req(lcdw_pkg::REQ_WRITE, 8'd240);
    send_req(lcdw_pkg::REQ_WRITE, 8'd210);

    // wrap after the first character, then again after a move
    set_wrap(7'd1, 1'b1);
    send_req(lcdw_pkg::REQ_CLEAR, 8'h00);
    send_req(lcdw_pkg::REQ_WRITE, 8'h41);
    send_req(lcdw_pkg::REQ_WRITE, 8'h42);
    send_req(lcdw_pkg::REQ_MOVE, 8'h40);
    send_req(lcdw_pkg::REQ_WRITE, 8'h43);

    // a wrap column of zero never matches
    set_wrap(7'd0, 1'b1);
    send_req(lcdw_pkg::REQ_CLEAR, 8'h00);
    send_req(lcdw_pkg::REQ_WRITE, 8'h31);
    send_req(lcdw_pkg::REQ_WRITE, 8'h32);
    send_req(lcdw_pkg::REQ_WRITE, 8'h33);

    // random phases over several settings
    run_phase(7'd20, 1'b0, 50, 1'b0);
    run_phase(7'd5, 1'b1, 70, 1'b1);
    run_phase(7'd80, 1'b1, 90, 1'b0);

    // count saturation with the widest wrap column
    set_wrap(7'd127, 1'b1);
    idle_on = 1'b1;
    send_line(131);

    run_phase(7'd1, 1'b1, 40, 1'b0);

    // last part runs without idling
    calm_end = 1'b1;
    idle_on  = 1'b0;
    run_phase(7'($urandom_range(2, 30)), 1'b1, 50, 1'b0);

    settle();
    $display("covered %0d requests and %0d bus events", items_sent, events_seen);
    $display("wrap columns 0, 1, 5, 20, 80 and 127, wrap on and off, with a long receiver hold");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d events still due", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
